// ===== hdl/rvg_pkg.sv =====
// Shared constants and controller/datapath interface types for the vector reduction block.
package rvg_pkg;

	localparam int VALUE_WIDTH_DEF = 16;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_last;
	} sts_t;

endpackage

// ===== hdl/rvg_datapath.sv =====
// Datapath: magnitudes, binary gcd, two restoring dividers and the output register.
module rvg_datapath #(
	parameter int VALUE_WIDTH = rvg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                    clk,
	input  rvg_pkg::cmd_t           cmd,
	output rvg_pkg::sts_t           sts,
	input  logic [VALUE_WIDTH-1:0]  x_delta,
	input  logic [VALUE_WIDTH-1:0]  y_delta,
	output logic [VALUE_WIDTH-1:0]  x_reduced,
	output logic [VALUE_WIDTH-1:0]  y_reduced
);

	localparam int W  = VALUE_WIDTH;
	localparam int KW = $clog2(W);

	logic [W-1:0]  a_q, b_q, g_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [W-1:0]  xd_q, yd_q, xr_q, yr_q;
	logic          xneg_q, yneg_q;
	logic [W-1:0]  x_out_q, y_out_q;
	logic [W-1:0]  x_mag, y_mag, g_comb;
	logic [W-1:0]  x_sh, y_sh;
	logic          x_ge, y_ge;

	assign x_mag  = x_delta[W-1] ? (~x_delta + 1'b1) : x_delta;
	assign y_mag  = y_delta[W-1] ? (~y_delta + 1'b1) : y_delta;
	assign g_comb = (a_q | b_q) << k_q;

	assign x_sh = {xr_q[W-2:0], xd_q[W-1]};
	assign y_sh = {yr_q[W-2:0], yd_q[W-1]};
	assign x_ge = (x_sh >= g_q);
	assign y_ge = (y_sh >= g_q);

	assign sts.gcd_done = (a_q == '0) || (b_q == '0);
	assign sts.div_last = (cnt_q == KW'(W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= x_mag;
			b_q    <= y_mag;
			k_q    <= '0;
			xd_q   <= x_mag;
			yd_q   <= y_mag;
			xneg_q <= x_delta[W-1];
			yneg_q <= y_delta[W-1];
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end else if (cmd.div_start) begin
			g_q   <= g_comb;
			xr_q  <= '0;
			yr_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			xr_q  <= x_ge ? (x_sh - g_q) : x_sh;
			yr_q  <= y_ge ? (y_sh - g_q) : y_sh;
			xd_q  <= {xd_q[W-2:0], x_ge};
			yd_q  <= {yd_q[W-2:0], y_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// A zero divisor only arises from the zero vector, which reduces to zero.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (g_q == '0) begin
				x_out_q <= '0;
				y_out_q <= '0;
			end else begin
				x_out_q <= xneg_q ? (~xd_q + 1'b1) : xd_q;
				y_out_q <= yneg_q ? (~yd_q + 1'b1) : yd_q;
			end
		end
	end

	assign x_reduced = x_out_q;
	assign y_reduced = y_out_q;

endmodule

// ===== hdl/rvg_ctrl.sv =====
// Controller state machine that sequences the gcd, the division and the output handoff.
module rvg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rvg_pkg::sts_t  sts,
	output rvg_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GCD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/reduce_vector_by_gcd.sv =====
// Top level: reduces a signed 2D vector to its primitive direction.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    x_delta, y_delta
// out      output     out_valid/out_ready  x_reduced, y_reduced
//
// A request is loaded, then runs binary gcd steps (one subtract or shift per cycle),
// latches the divisor, runs bit-serial division of both components in parallel, and
// finally fills the output register.
// One request is worked on at a time; a finished result waits in the output register
// while the next request is taken in, and the controller holds before loading a new result
// while that register is still full. Reset clears only the controller state and out_valid.
module reduce_vector_by_gcd #(
	parameter int VALUE_WIDTH = rvg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] x_delta,
	input  logic [VALUE_WIDTH-1:0] y_delta,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] x_reduced,
	output logic [VALUE_WIDTH-1:0] y_reduced
);

	rvg_pkg::cmd_t cmd;
	rvg_pkg::sts_t sts;

	rvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvg_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.x_delta   (x_delta),
		.y_delta   (y_delta),
		.x_reduced (x_reduced),
		.y_reduced (y_reduced)
	);

endmodule

// ===== tb/tb_reduce_vector_by_gcd.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for reduce_vector_by_gcd: directed corner vectors, then random requests.
module tb_reduce_vector_by_gcd;

	localparam int W = rvg_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_REQUESTS = 1150;
	localparam int HOLD_AFTER_RESULTS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int STEADY_FIRST = 600;
	localparam int STEADY_LAST = 700;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [W-1:0] xr;
		logic [W-1:0] yr;
	} direction_t;

	typedef struct packed {
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic         known;
		logic [W-1:0] ex;
		logic [W-1:0] ey;
	} vector_case_t;

	localparam int N_DIRECTED = 22;
	localparam vector_case_t DIRECTED_CASES [N_DIRECTED] = '{
		'{16'd0,       16'd0,       1'b1, 16'd0,       16'd0},
		'{16'd0,       16'd5,       1'b1, 16'd0,       16'd1},
		'{-16'sd7,     16'd0,       1'b1, -16'sd1,     16'd0},
		'{16'd0,       -16'sd32767, 1'b1, 16'd0,       -16'sd1},
		'{16'sd32767,  16'sd32767,  1'b1, 16'd1,       16'd1},
		'{-16'sd32767, 16'sd32767,  1'b1, -16'sd1,     16'd1},
		'{16'h8000,    16'h8000,    1'b1, -16'sd1,     -16'sd1},
		'{16'h8000,    16'd0,       1'b1, -16'sd1,     16'd0},
		'{16'd0,       16'h8000,    1'b1, 16'd0,       -16'sd1},
		'{16'h8000,    16'd1,       1'b1, 16'h8000,    16'd1},
		'{16'sd32767,  16'h8000,    1'b1, 16'sd32767,  16'h8000},
		'{16'h8000,    16'sd16384,  1'b1, -16'sd2,     16'd1},
		'{16'd1,       16'd1,       1'b1, 16'd1,       16'd1},
		'{-16'sd1,     -16'sd1,     1'b1, -16'sd1,     -16'sd1},
		'{16'sd32767,  -16'sd1,     1'b1, 16'sd32767,  -16'sd1},
		'{16'd6,       16'd4,       1'b0, 16'd0,       16'd0},
		'{-16'sd12,    16'sd18,     1'b0, 16'd0,       16'd0},
		'{16'sd30030,  -16'sd2310,  1'b0, 16'd0,       16'd0},
		'{16'h5555,    16'h2aaa,    1'b0, 16'd0,       16'd0},
		'{16'haaaa,    16'h5556,    1'b0, 16'd0,       16'd0},
		'{16'sd1024,   -16'sd4096,  1'b0, 16'd0,       16'd0},
		'{16'sd32759,  16'sd17,     1'b0, 16'd0,       16'd0}
	};

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [W-1:0] x_delta;
	logic [W-1:0] y_delta;
	logic         out_valid;
	logic         out_ready;
	logic [W-1:0] x_reduced;
	logic [W-1:0] y_reduced;

	direction_t pending_directions[$];
	int         failures = 0;
	int         requests_sent = 0;
	int         results_seen = 0;
	int         divisor_cases = 0;
	int         zero_vectors = 0;
	int         idle_cycles = 0;
	bit         hold_done = 0;

	reduce_vector_by_gcd #(
		.VALUE_WIDTH(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_delta(x_delta),
		.y_delta(y_delta),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_reduced(x_reduced),
		.y_reduced(y_reduced)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [W:0] magnitude(input logic [W-1:0] v);
		if (v[W-1]) begin
			return {1'b1, {W{1'b0}}} - {1'b0, v};
		end
		return {1'b0, v};
	endfunction

	function automatic direction_t primitive_direction(input logic [W-1:0] x,
			input logic [W-1:0] y);
		logic [W:0] mx;
		logic [W:0] my;
		logic [W:0] a;
		logic [W:0] b;
		logic [W:0] r;
		logic [W:0] qx;
		logic [W:0] qy;
		direction_t d;
		mx = magnitude(x);
		my = magnitude(y);
		a = mx;
		b = my;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		if (a == 0) begin
			d.xr = '0;
			d.yr = '0;
			return d;
		end
		qx = mx / a;
		qy = my / a;
		d.xr = x[W-1] ? -qx[W-1:0] : qx[W-1:0];
		d.yr = y[W-1] ? -qy[W-1:0] : qy[W-1:0];
		return d;
	endfunction

	function automatic int sender_gap(input int index);
		int r;
		if (index >= STEADY_FIRST && index < STEADY_LAST) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(15, 60);
	endfunction

	task automatic random_vector(output logic [W-1:0] x, output logic [W-1:0] y);
		int mode;
		int g;
		int a;
		int b;
		mode = $urandom_range(0, 99);
		x = W'($urandom);
		y = W'($urandom);
		if (mode < 35) begin
			return;
		end
		if (mode < 70) begin
			if ($urandom_range(0, 3) == 0) begin
				g = 1 << $urandom_range(1, 14);
			end else begin
				g = $urandom_range(2, 3000);
			end
			a = $urandom_range(0, 32767 / g) * g;
			b = $urandom_range(0, 32767 / g) * g;
			x = W'($urandom_range(0, 1) ? -a : a);
			y = W'($urandom_range(0, 1) ? -b : b);
		end else if (mode < 82) begin
			x = W'($urandom_range(0, 40) - 20);
			y = W'($urandom_range(0, 40) - 20);
		end else if (mode < 88) begin
			if ($urandom_range(0, 1)) begin
				x = '0;
			end else begin
				y = '0;
			end
		end else if (mode < 94) begin
			x = {1'b1, {(W-1){1'b0}}};
			if ($urandom_range(0, 1)) begin
				a = 1 << $urandom_range(0, 15);
				y = W'($urandom_range(0, 1) ? -a : a);
			end
			if ($urandom_range(0, 1)) begin
				{x, y} = {y, x};
			end
		end else begin
			a = $urandom_range(1, 32767);
			x = W'($urandom_range(0, 1) ? -a : a);
			y = W'($urandom_range(0, 1) ? -a : a);
		end
	endtask

	task automatic offer_vector(input logic [W-1:0] x, input logic [W-1:0] y,
			input direction_t want);
		in_valid = 1'b1;
		x_delta = x;
		y_delta = y;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_directions.push_back(want);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender(input int gap);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Result side: random stalls, one long hold-off to back the block up, and a steady window.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				out_ready = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
			end else if (results_seen >= STEADY_FIRST && results_seen < STEADY_LAST) begin
				out_ready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready = 1'b1;
				end else begin
					out_ready = 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin
		direction_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_directions.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d", $time,
					$signed(x_reduced), $signed(y_reduced));
				failures++;
			end else begin
				want = pending_directions.pop_front();
				if (x_reduced !== want.xr) begin
					$display("%0t: x_reduced expected %0d, got %0d", $time,
						$signed(want.xr), $signed(x_reduced));
					failures++;
				end
				if (y_reduced !== want.yr) begin
					$display("%0t: y_reduced expected %0d, got %0d", $time,
						$signed(want.yr), $signed(y_reduced));
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
					IDLE_LIMIT, pending_directions.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [W-1:0] x;
		logic [W-1:0] y;
		direction_t   want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_delta = '0;
		y_delta = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_CASES[i].known) begin
				want.xr = DIRECTED_CASES[i].ex;
				want.yr = DIRECTED_CASES[i].ey;
			end else begin
				want = primitive_direction(DIRECTED_CASES[i].x, DIRECTED_CASES[i].y);
			end
			offer_vector(DIRECTED_CASES[i].x, DIRECTED_CASES[i].y, want);
			pause_sender(sender_gap(i + STEADY_LAST));
		end

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			random_vector(x, y);
			want = primitive_direction(x, y);
			if (x == 0 && y == 0) begin
				zero_vectors++;
			end else if (want != {x, y}) begin
				divisor_cases++;
			end
			offer_vector(x, y, want);
			pause_sender(sender_gap(i));
		end
		in_valid = 1'b0;

		while (pending_directions.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed): %0d random ones shared a divisor above one,",
			requests_sent, N_DIRECTED, divisor_cases);
		$display("%0d were zero vectors; %0d results checked, output held off once for %0d cycles.",
			zero_vectors, results_seen, HOLD_CYCLES);
		if (failures == 0 && pending_directions.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
